### rtl/emsg_pkg.sv
// ============================================================================
// emsg_pkg: shared widths, latencies and types
// Widths and pipeline depths used by the gravity pull pipeline and its units.
// ============================================================================
`default_nettype none

package emsg_pkg;

  localparam int D_W      = 33;             // signed position difference
  localparam int MAG_W    = 33;             // magnitude of a difference
  localparam int SQ_W     = 2 * MAG_W;      // one squared component
  localparam int R2_W     = SQ_W + 1;       // squared distance
  localparam int ROOT_W   = 34;             // integer root of R2_W bits
  localparam int SQ_LAT   = ROOT_W;         // one root bit per stage
  localparam int DEN_W    = R2_W + ROOT_W;  // r^2 * r
  localparam int GM_W     = 49;             // Earth and Moon GM registers
  localparam int GS_W     = 32;             // satellite GM register
  localparam int G_SHIFT  = 32;             // m^3/s^2 to 2^-32 units
  localparam int G_W      = GM_W + G_SHIFT; // scaled GM
  localparam int NUM_W    = G_W + MAG_W;    // GM * |d|
  localparam int Q_W      = 48;             // quotient bits kept
  localparam int DIV_LAT  = Q_W + 1;        // range check plus one bit per stage
  localparam int ACC_W    = 48;             // output acceleration
  localparam int PULL_W   = ACC_W + 1;      // one pull, range +-2^47
  localparam int SUM_W    = PULL_W + 1;     // two pulls added
  localparam int PULL_LAT = SQ_LAT + DIV_LAT + 6;
  localparam int R2_SPLIT = 23;             // chunking of r^2 for r^2 * r
  localparam int G_SPLIT  = 27;             // chunking of GM for GM * |d|

  localparam logic [Q_W-1:0] Q_CLIP = Q_W'(1) << (ACC_W - 1);
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'({1'b0, Q_CLIP} - 1'b1);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(0) - SUM_W'(Q_CLIP);

  // Result of one point-mass pull.
  typedef struct packed {
    logic signed [PULL_W-1:0] ax;
    logic signed [PULL_W-1:0] ay;
    logic                     flag;
  } pull_res_t;

  // Magnitudes and signs of one difference vector.
  typedef struct packed {
    logic [MAG_W-1:0] mx;
    logic [MAG_W-1:0] my;
    logic             sx;
    logic             sy;
  } side_t;

endpackage

`default_nettype wire

### rtl/earth_moon_sat_gravity_accel.sv
// ============================================================================
// earth_moon_sat_gravity_accel: planar Earth/Moon/satellite gravity
// Pipelined fixed-point accelerations of the satellite and the Moon.
// ============================================================================
// Usage:
// An item is the satellite and Moon positions in signed metres with Earth at
// the origin. It is taken at a rising edge where start is high and busy is
// low. busy never rises, so one item can be taken in every cycle.
// Each item gives one result: both bodies' accelerations in units of
// 2^-32 m/s^2, saturated to 48 bits, and a flag for a zero distance or a
// clipped value. done marks the result for exactly one cycle, and results leave
// in the order the items came.
// The depth is set by the square root (one bit per stage, 34 stages) and the
// two dividers of each pull (one quotient bit per stage, 49 stages), with
// the four pulls running side by side.
// The receiver cannot stall: every result is shown once and then dropped.
// Reset clears the pipeline valid bits and the strobe and loads the default
// GM values. The GM registers sit on an APB port at byte addresses 0, 8 and
// 16 and should be written only while no item is in flight.
// ============================================================================
`default_nettype none

module earth_moon_sat_gravity_accel (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [31:0]                 sat_x,
  input  logic signed [31:0]                 sat_y,
  input  logic signed [31:0]                 moon_x,
  input  logic signed [31:0]                 moon_y,
  output logic                               done,
  output logic signed [emsg_pkg::ACC_W-1:0]  sat_ax,
  output logic signed [emsg_pkg::ACC_W-1:0]  sat_ay,
  output logic signed [emsg_pkg::ACC_W-1:0]  moon_ax,
  output logic signed [emsg_pkg::ACC_W-1:0]  moon_ay,
  output logic                               saturated,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [4:0]                         paddr,
  input  logic [63:0]                        pwdata,
  output logic [63:0]                        prdata,
  output logic                               pready
);
  import emsg_pkg::*;

  localparam logic [1:0] REG_GM_EARTH = 2'd0;
  localparam logic [1:0] REG_GM_MOON  = 2'd1;
  localparam logic [1:0] REG_GM_SAT   = 2'd2;

  logic [GM_W-1:0] gm_earth, gm_moon;
  logic [GS_W-1:0] gm_satellite;

  logic                  vld [0:PULL_LAT];
  logic signed [D_W-1:0] es_x, es_y, ms_x, ms_y, em_x, em_y, sm_x, sm_y;
  pull_res_t             p_es, p_ms, p_em, p_sm;
  logic [G_W-1:0]        g_earth, g_moon, g_sat;
  logic [ACC_W:0]        c_sx, c_sy, c_mx, c_my;

  // Adds the two pulls on one axis and clips to the output range; the top
  // bit of the result flags a clip.
  function automatic logic [ACC_W:0] clip_sum(input logic signed [PULL_W-1:0] a,
                                              input logic signed [PULL_W-1:0] b);
    logic signed [SUM_W-1:0] s;
    s = {a[PULL_W-1], a} + {b[PULL_W-1], b};
    if (s > SUM_MAX) begin
      return {1'b1, SUM_MAX[ACC_W-1:0]};
    end else if (s < SUM_MIN) begin
      return {1'b1, SUM_MIN[ACC_W-1:0]};
    end
    return {1'b0, s[ACC_W-1:0]};
  endfunction

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      gm_earth     <= GM_W'(64'd398499700000000);
      gm_moon      <= GM_W'(64'd4902801000000);
      gm_satellite <= GS_W'(64'd8263);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:3])
        REG_GM_EARTH: gm_earth     <= pwdata[GM_W-1:0];
        REG_GM_MOON:  gm_moon      <= pwdata[GM_W-1:0];
        REG_GM_SAT:   gm_satellite <= pwdata[GS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_GM_EARTH: prdata = 64'(gm_earth);
      REG_GM_MOON:  prdata = 64'(gm_moon);
      REG_GM_SAT:   prdata = 64'(gm_satellite);
      default:      prdata = '0;
    endcase
  end

  // Earth and Moon GM are given in m^3/s^2 and scaled into 2^-32 units here;
  // the satellite GM is already in those units.
  assign g_earth = {gm_earth, {G_SHIFT{1'b0}}};
  assign g_moon  = {gm_moon, {G_SHIFT{1'b0}}};
  assign g_sat   = G_W'(gm_satellite);

  // Valid bits run alongside the data; nothing in the pipe ever waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= PULL_LAT; i++) vld[i] <= 1'b0;
      done <= 1'b0;
    end else begin
      vld[0] <= start;
      for (int i = 1; i <= PULL_LAT; i++) vld[i] <= vld[i-1];
      done <= vld[PULL_LAT];
    end
  end

  // Input stage: the vector from each pulled body to its pulling body.
  always_ff @(posedge clk) begin
    es_x <= D_W'(0) - {sat_x[31], sat_x};
    es_y <= D_W'(0) - {sat_y[31], sat_y};
    ms_x <= {moon_x[31], moon_x} - {sat_x[31], sat_x};
    ms_y <= {moon_y[31], moon_y} - {sat_y[31], sat_y};
    em_x <= D_W'(0) - {moon_x[31], moon_x};
    em_y <= D_W'(0) - {moon_y[31], moon_y};
    sm_x <= {sat_x[31], sat_x} - {moon_x[31], moon_x};
    sm_y <= {sat_y[31], sat_y} - {moon_y[31], moon_y};
  end

  // Earth on the satellite.
  emsg_pull u_pull_es (.clk(clk), .dx(es_x), .dy(es_y), .g(g_earth), .res(p_es));
  // Moon on the satellite.
  emsg_pull u_pull_ms (.clk(clk), .dx(ms_x), .dy(ms_y), .g(g_moon), .res(p_ms));
  // Earth on the Moon.
  emsg_pull u_pull_em (.clk(clk), .dx(em_x), .dy(em_y), .g(g_earth), .res(p_em));
  // Satellite on the Moon.
  emsg_pull u_pull_sm (.clk(clk), .dx(sm_x), .dy(sm_y), .g(g_sat), .res(p_sm));

  assign c_sx = clip_sum(p_es.ax, p_ms.ax);
  assign c_sy = clip_sum(p_es.ay, p_ms.ay);
  assign c_mx = clip_sum(p_em.ax, p_sm.ax);
  assign c_my = clip_sum(p_em.ay, p_sm.ay);

  // Output register: holds the result for the one cycle that done is high.
  always_ff @(posedge clk) begin
    if (vld[PULL_LAT]) begin
      sat_ax    <= c_sx[ACC_W-1:0];
      sat_ay    <= c_sy[ACC_W-1:0];
      moon_ax   <= c_mx[ACC_W-1:0];
      moon_ay   <= c_my[ACC_W-1:0];
      saturated <= p_es.flag || p_ms.flag || p_em.flag || p_sm.flag
                || c_sx[ACC_W] || c_sy[ACC_W] || c_mx[ACC_W] || c_my[ACC_W];
    end
  end

endmodule

`default_nettype wire

### rtl/emsg_isqrt.sv
// ============================================================================
// emsg_isqrt: pipelined integer square root
// Digit-by-digit floor root, one result bit per register stage.
// ============================================================================
`default_nettype none

module emsg_isqrt (
  input  logic                        clk,
  input  logic [emsg_pkg::R2_W-1:0]   x,
  output logic [emsg_pkg::ROOT_W-1:0] root
);
  import emsg_pkg::*;

  localparam int TW = R2_W + 1;

  logic [R2_W-1:0]   rem [0:ROOT_W-2];
  logic [ROOT_W-1:0] res [0:ROOT_W-1];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic [R2_W-1:0]   rin;
    logic [ROOT_W-1:0] sin;
    logic [TW-1:0]     trial;
    logic              take;

    if (k == 0) begin : g_first
      assign rin = x;
      assign sin = '0;
    end else begin : g_next
      assign rin = rem[k-1];
      assign sin = res[k-1];
    end

    assign trial = ({{(TW-ROOT_W){1'b0}}, sin} << (B + 1))
                 | ({{(TW-1){1'b0}}, 1'b1} << (2 * B));
    assign take  = {1'b0, rin} >= trial;

    always_ff @(posedge clk) begin
      res[k] <= take ? (sin | ({{(ROOT_W-1){1'b0}}, 1'b1} << B)) : sin;
    end

    if (k < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem[k] <= take ? (rin - trial[R2_W-1:0]) : rin;
      end
    end
  end

  assign root = res[ROOT_W-1];

endmodule

`default_nettype wire

### rtl/emsg_div.sv
// ============================================================================
// emsg_div: pipelined restoring divider
// Quotient bits below the output range, one bit per stage, with a range flag.
// ============================================================================
`default_nettype none

module emsg_div (
  input  logic                       clk,
  input  logic [emsg_pkg::NUM_W-1:0] num,
  input  logic [emsg_pkg::DEN_W-1:0] den,
  output logic [emsg_pkg::Q_W-1:0]   quo,
  output logic                       over
);
  import emsg_pkg::*;

  localparam int TRIAL_W = DEN_W + Q_W;

  logic [NUM_W-1:0] rem [0:Q_W-1];
  logic [DEN_W-1:0] dd  [0:Q_W-1];
  logic [Q_W-1:0]   q   [0:Q_W];
  logic             ov  [0:Q_W];

  // The quotient fits in Q_W bits exactly when num < den * 2^Q_W.
  always_ff @(posedge clk) begin
    rem[0] <= num;
    dd[0]  <= den;
    q[0]   <= '0;
    ov[0]  <= {{(TRIAL_W-NUM_W){1'b0}}, num} >= {den, {Q_W{1'b0}}};
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_stage
    localparam int B = Q_W - k;
    logic [TRIAL_W-1:0] trial;
    logic               take;

    assign trial = {{Q_W{1'b0}}, dd[k-1]} << B;
    assign take  = {{(TRIAL_W-NUM_W){1'b0}}, rem[k-1]} >= trial;

    always_ff @(posedge clk) begin
      ov[k] <= ov[k-1];
      q[k]  <= take ? (q[k-1] | ({{(Q_W-1){1'b0}}, 1'b1} << B)) : q[k-1];
    end

    if (k < Q_W) begin : g_carry
      always_ff @(posedge clk) begin
        dd[k]  <= dd[k-1];
        rem[k] <= take ? (rem[k-1] - trial[NUM_W-1:0]) : rem[k-1];
      end
    end
  end

  assign quo  = q[Q_W];
  assign over = ov[Q_W];

endmodule

`default_nettype wire

### rtl/emsg_pull.sv
// ============================================================================
// emsg_pull: one point-mass pull GM * d / r^3
// Squares, root, products and two divisions in a fixed-latency pipeline.
// ============================================================================
`default_nettype none

module emsg_pull (
  input  logic                            clk,
  input  logic signed [emsg_pkg::D_W-1:0] dx,
  input  logic signed [emsg_pkg::D_W-1:0] dy,
  input  logic [emsg_pkg::G_W-1:0]        g,
  output emsg_pkg::pull_res_t             res
);
  import emsg_pkg::*;

  localparam int SIDE_LEN = SQ_LAT + DIV_LAT + 4;
  localparam int Z_LEN    = SQ_LAT + DIV_LAT + 2;
  localparam int DP_W     = R2_SPLIT + ROOT_W;
  localparam int DPT_W    = R2_W - 2 * R2_SPLIT + ROOT_W;
  localparam int GP_W     = G_SPLIT + MAG_W;

  side_t            s1;
  side_t            side_d [0:SIDE_LEN-1];
  logic [SQ_W-1:0]  sqx, sqy;
  logic [R2_W-1:0]  r2;
  logic             zero;
  logic [R2_W-1:0]  r2_d [0:SQ_LAT-1];
  logic             z_d  [0:Z_LEN-1];
  logic [ROOT_W-1:0] root;

  logic [DP_W-1:0]  dp0, dp1;
  logic [DPT_W-1:0] dp2;
  logic [GP_W-1:0]  nx0, nx1, nx2, ny0, ny1, ny2;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] numx, numy;
  logic [Q_W-1:0]   qx, qy;
  logic             ovx, ovy;

  side_t            sf;
  logic             clipx, clipy;
  logic [Q_W-1:0]   mgx, mgy;
  logic [R2_W-1:0]  r2t;
  side_t            st;

  always_ff @(posedge clk) begin
    s1.mx <= dx[D_W-1] ? MAG_W'(~dx + 1'b1) : MAG_W'(dx);
    s1.my <= dy[D_W-1] ? MAG_W'(~dy + 1'b1) : MAG_W'(dy);
    s1.sx <= dx[D_W-1];
    s1.sy <= dy[D_W-1];
    sqx   <= s1.mx * s1.mx;
    sqy   <= s1.my * s1.my;
    r2    <= {1'b0, sqx} + {1'b0, sqy};
    zero  <= (sqx == '0) && (sqy == '0);
  end

  always_ff @(posedge clk) begin
    side_d[0] <= s1;
    r2_d[0]   <= r2;
    z_d[0]    <= zero;
    for (int i = 1; i < SIDE_LEN; i++) side_d[i] <= side_d[i-1];
    for (int i = 1; i < SQ_LAT; i++)   r2_d[i]   <= r2_d[i-1];
    for (int i = 1; i < Z_LEN; i++)    z_d[i]    <= z_d[i-1];
  end

  emsg_isqrt u_isqrt (
    .clk  (clk),
    .x    (r2),
    .root (root)
  );

  assign r2t = r2_d[SQ_LAT-1];
  assign st  = side_d[SQ_LAT+1];

  // Partial products, then their aligned sums.
  always_ff @(posedge clk) begin
    dp0  <= r2t[R2_SPLIT-1:0] * root;
    dp1  <= r2t[2*R2_SPLIT-1:R2_SPLIT] * root;
    dp2  <= r2t[R2_W-1:2*R2_SPLIT] * root;
    nx0  <= g[G_SPLIT-1:0] * st.mx;
    nx1  <= g[2*G_SPLIT-1:G_SPLIT] * st.mx;
    nx2  <= g[G_W-1:2*G_SPLIT] * st.mx;
    ny0  <= g[G_SPLIT-1:0] * st.my;
    ny1  <= g[2*G_SPLIT-1:G_SPLIT] * st.my;
    ny2  <= g[G_W-1:2*G_SPLIT] * st.my;
    den  <= DEN_W'(dp0) + (DEN_W'(dp1) << R2_SPLIT) + (DEN_W'(dp2) << (2 * R2_SPLIT));
    numx <= NUM_W'(nx0) + (NUM_W'(nx1) << G_SPLIT) + (NUM_W'(nx2) << (2 * G_SPLIT));
    numy <= NUM_W'(ny0) + (NUM_W'(ny1) << G_SPLIT) + (NUM_W'(ny2) << (2 * G_SPLIT));
  end

  emsg_div u_div_x (
    .clk  (clk),
    .num  (numx),
    .den  (den),
    .quo  (qx),
    .over (ovx)
  );

  emsg_div u_div_y (
    .clk  (clk),
    .num  (numy),
    .den  (den),
    .quo  (qy),
    .over (ovy)
  );

  assign sf = side_d[SIDE_LEN-1];

  always_comb begin
    clipx = ovx || (qx > Q_CLIP);
    clipy = ovy || (qy > Q_CLIP);
    mgx   = clipx ? Q_CLIP : qx;
    mgy   = clipy ? Q_CLIP : qy;
  end

  // Coincident bodies give no pull but still raise the flag.
  always_ff @(posedge clk) begin
    if (z_d[Z_LEN-1]) begin
      res.ax <= '0;
      res.ay <= '0;
    end else begin
      res.ax <= sf.sx ? (PULL_W'(0) - {1'b0, mgx}) : {1'b0, mgx};
      res.ay <= sf.sy ? (PULL_W'(0) - {1'b0, mgy}) : {1'b0, mgy};
    end
    res.flag <= z_d[Z_LEN-1] || clipx || clipy;
  end

endmodule

`default_nettype wire
